FILE: rtl/stqps_pkg.sv
// Shared constants and types for the sorted-table quadratic-probe search.
package stqps_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int PROD_W      = 2 * CNT_W;
   localparam int DIV_STEPS   = CNT_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);
   localparam int WORD_W      = 32;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHK_LO,
      ST_CHK_HI,
      ST_MUL,
      ST_DIV,
      ST_PROBE,
      ST_CMP,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/sorted_table_quadratic_probe_search.sv
// Sorted-table search with a quadratic probe step, sequenced over one reused divider.
//
//  Channel  Ports                                   Direction  Beat contents
//  req      req_valid/req_ready                     in         write entry or search key
//  rsp      rsp_valid/rsp_ready                     out        found flag and position
//  csr      csr_wr_en/csr_wr_data                   in         entry count, no handshake
//
// A write beat goes straight into the table. A search beat runs the low and high
// bound checks, then per probe a multiply, 11 divider steps, an address step and a
// compare, and finally loads the result register; the probe count depends on the
// data. An 11-step restoring divider forms floor(r*r/N).
// Reset is synchronous and active high; it clears the sequencer, the entry count and
// the result valid flag. The table itself is not cleared and reads back undefined
// until written. A stalled result holds in the output register while the block
// already accepts and works on the next beat; a finished search waits there for it.
module sorted_table_quadratic_probe_search (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic        [stqps_pkg::IDX_W-1:0]  req_entry_index,
   input  logic signed [stqps_pkg::WORD_W-1:0] req_entry_value,
   input  logic signed [stqps_pkg::WORD_W-1:0] req_search_key,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic        [stqps_pkg::IDX_W-1:0]  rsp_position,
   input  logic                                csr_wr_en,
   input  logic        [stqps_pkg::CNT_W-1:0]  csr_wr_data
);

   // Sequencer state.
   stqps_pkg::state_type state_ff, state_in;

   // Configuration register.
   logic [stqps_pkg::CNT_W-1:0] count_ff;

   // Table memory with a registered read port.
   logic signed [stqps_pkg::WORD_W-1:0] mem [stqps_pkg::TABLE_DEPTH];
   logic signed [stqps_pkg::WORD_W-1:0] rd_data_ff;
   logic        [stqps_pkg::IDX_W-1:0]  rd_addr;
   logic                                mem_we;

   // Search datapath.
   logic signed [stqps_pkg::WORD_W-1:0] key_ff, key_in;
   logic [stqps_pkg::CNT_W-1:0]         n_ff, n_in;
   logic [stqps_pkg::IDX_W-1:0]         lo_ff, lo_in;
   logic [stqps_pkg::IDX_W-1:0]         hi_ff, hi_in;
   logic [stqps_pkg::IDX_W-1:0]         cur_ff, cur_in;
   logic [stqps_pkg::CNT_W-1:0]         rem_ff, rem_in;
   logic [stqps_pkg::CNT_W-1:0]         dvd_ff, dvd_in;
   logic [stqps_pkg::STEP_W-1:0]        step_ff, step_in;
   logic                                hit_ff, hit_in;

   // Result register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [stqps_pkg::IDX_W-1:0] rsp_position_ff, rsp_position_in;

   // Combinational helpers.
   logic                        req_fire;
   logic [stqps_pkg::CNT_W-1:0] n_eff;
   logic [stqps_pkg::CNT_W-1:0] range_size;
   logic [stqps_pkg::PROD_W-1:0] product;
   logic [stqps_pkg::CNT_W:0]   trial;
   logic                        trial_ge;
   logic [stqps_pkg::CNT_W:0]   trial_diff;
   logic [stqps_pkg::CNT_W-1:0] jump;
   logic [stqps_pkg::CNT_W:0]   probe_sum;
   logic [stqps_pkg::IDX_W-1:0] probe_idx;
   logic                        out_free;
   logic                        last_step;

   assign req_ready    = (state_ff == stqps_pkg::ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign mem_we       = req_fire && (req_type == stqps_pkg::REQ_WRITE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;
   assign out_free     = !rsp_valid_ff || rsp_ready;

   // A count beyond the table depth searches the whole table.
   assign n_eff = (count_ff > stqps_pkg::CNT_W'(stqps_pkg::TABLE_DEPTH)) ?
                  stqps_pkg::CNT_W'(stqps_pkg::TABLE_DEPTH) : count_ff;

   // The remaining range holds hi - lo + 1 entries; its square is the dividend.
   assign range_size = {1'b0, hi_ff} - {1'b0, lo_ff} + stqps_pkg::CNT_W'(1);
   assign product    = stqps_pkg::PROD_W'(range_size) * stqps_pkg::PROD_W'(range_size);

   // One restoring division step. The quotient never exceeds the range size, so the
   // upper half of the dividend is already below N and only CNT_W steps are needed.
   assign trial      = {rem_ff, dvd_ff[stqps_pkg::CNT_W-1]};
   assign trial_ge   = (trial >= {1'b0, n_ff});
   assign trial_diff = trial - {1'b0, n_ff};
   assign last_step  = (step_ff == stqps_pkg::STEP_W'(stqps_pkg::DIV_STEPS - 1));

   // The probe aims at least one entry past lo and is clamped to hi.
   assign jump      = (dvd_ff == '0) ? stqps_pkg::CNT_W'(1) : dvd_ff;
   assign probe_sum = {2'b00, lo_ff} + {1'b0, jump};
   assign probe_idx = (probe_sum > {2'b00, hi_ff}) ? hi_ff : probe_sum[stqps_pkg::IDX_W-1:0];

   // Read address: the first entry while idle, the last entry during the low bound
   // check, and the probe while it is being formed.
   always_comb begin
      unique case (state_ff)
         stqps_pkg::ST_CHK_LO: rd_addr = stqps_pkg::IDX_W'(n_ff - stqps_pkg::CNT_W'(1));
         stqps_pkg::ST_PROBE:  rd_addr = probe_idx;
         default:              rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[req_entry_index] <= req_entry_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stqps_pkg::ST_IDLE: begin
            if (req_fire && (req_type == stqps_pkg::REQ_SEARCH)) begin
               state_in = (n_eff == '0) ? stqps_pkg::ST_DONE : stqps_pkg::ST_CHK_LO;
            end
         end
         stqps_pkg::ST_CHK_LO: begin
            state_in = (key_ff < rd_data_ff) ? stqps_pkg::ST_DONE : stqps_pkg::ST_CHK_HI;
         end
         stqps_pkg::ST_CHK_HI: begin
            state_in = (key_ff > rd_data_ff) ? stqps_pkg::ST_DONE : stqps_pkg::ST_MUL;
         end
         stqps_pkg::ST_MUL: begin
            state_in = stqps_pkg::ST_DIV;
         end
         stqps_pkg::ST_DIV: begin
            if (last_step) begin
               state_in = stqps_pkg::ST_PROBE;
            end
         end
         stqps_pkg::ST_PROBE: begin
            state_in = stqps_pkg::ST_CMP;
         end
         stqps_pkg::ST_CMP: begin
            priority if (rd_data_ff == key_ff) begin
               state_in = stqps_pkg::ST_DONE;
            end else if (rd_data_ff < key_ff) begin
               state_in = (cur_ff == hi_ff) ? stqps_pkg::ST_DONE : stqps_pkg::ST_MUL;
            end else begin
               state_in = (cur_ff == lo_ff) ? stqps_pkg::ST_DONE : stqps_pkg::ST_MUL;
            end
         end
         stqps_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = stqps_pkg::ST_IDLE;
            end
         end
         default: state_in = stqps_pkg::ST_IDLE;
      endcase
   end

   // Datapath and result register next values.
   always_comb begin
      key_in          = key_ff;
      n_in            = n_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      cur_in          = cur_ff;
      rem_in          = rem_ff;
      dvd_in          = dvd_ff;
      step_in         = step_ff;
      hit_in          = hit_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;

      unique case (state_ff)
         stqps_pkg::ST_IDLE: begin
            if (req_fire) begin
               key_in = req_search_key;
               n_in   = n_eff;
               hit_in = 1'b0;
            end
         end
         stqps_pkg::ST_CHK_LO: begin
            lo_in = '0;
            hi_in = stqps_pkg::IDX_W'(n_ff - stqps_pkg::CNT_W'(1));
         end
         stqps_pkg::ST_MUL: begin
            rem_in  = product[stqps_pkg::PROD_W-1:stqps_pkg::CNT_W];
            dvd_in  = product[stqps_pkg::CNT_W-1:0];
            step_in = '0;
         end
         stqps_pkg::ST_DIV: begin
            rem_in  = trial_ge ? trial_diff[stqps_pkg::CNT_W-1:0]
                               : trial[stqps_pkg::CNT_W-1:0];
            dvd_in  = {dvd_ff[stqps_pkg::CNT_W-2:0], trial_ge};
            step_in = step_ff + stqps_pkg::STEP_W'(1);
         end
         stqps_pkg::ST_PROBE: begin
            cur_in = probe_idx;
         end
         stqps_pkg::ST_CMP: begin
            priority if (rd_data_ff == key_ff) begin
               hit_in = 1'b1;
            end else if (rd_data_ff < key_ff) begin
               lo_in = cur_ff + stqps_pkg::IDX_W'(1);
            end else begin
               hi_in = cur_ff - stqps_pkg::IDX_W'(1);
            end
         end
         stqps_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = hit_ff;
               rsp_position_in = hit_ff ? cur_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stqps_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      n_ff            <= n_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      cur_ff          <= cur_in;
      rem_ff          <= rem_in;
      dvd_ff          <= dvd_in;
      step_ff         <= step_in;
      hit_ff          <= hit_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   // The remaining range is never empty when a probe step starts.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == stqps_pkg::ST_MUL) |-> (lo_ff <= hi_ff) && (hi_ff < n_ff))
      else $error("search range invalid at probe start");

   // The divider remainder always stays below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == stqps_pkg::ST_DIV) |-> (rem_ff < n_ff))
      else $error("divider remainder out of range");

   // The probe always lies inside the remaining range.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == stqps_pkg::ST_CMP) |-> (cur_ff >= lo_ff) && (cur_ff <= hi_ff))
      else $error("probe outside search range");

   // A search on an empty table goes straight to the result.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_type == stqps_pkg::REQ_SEARCH) && (n_eff == '0)
      |=> (state_ff == stqps_pkg::ST_DONE))
      else $error("empty table search did not finish at once");

   // A miss always reports position zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> (rsp_position_ff == '0))
      else $error("miss with nonzero position");

endmodule

FILE: bench/tb_sorted_table_quadratic_probe_search.sv
// Self-checking testbench for the sorted-table quadratic-probe search block.
`timescale 1ns / 1ps

module tb_sorted_table_quadratic_probe_search;

   // Timing and run-length figures. Even a full table rarely needs more than sixty
   // probes, so the cycle limit leaves a wide margin over the slowest correct run.
   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 11;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES = 64;
   localparam int HOLD_CYCLES = 3000;
   localparam int RANDOM_BEATS = 560;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int COUNT_MAX = (1 << stqps_pkg::CNT_W) - 1;

   // How tightly the values of a freshly loaded table are packed. Dense tables
   // give many duplicates, and wide tables reach the extremes of the word.
   typedef enum int {
      SPREAD_WIDE,
      SPREAD_MEDIUM,
      SPREAD_DENSE
   } spread_type;

   typedef struct packed {
      logic                        found;
      logic [stqps_pkg::IDX_W-1:0] position;
   } lookup_result_type;

   // Every block input has a known value from time zero.
   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic                                req_type = stqps_pkg::REQ_WRITE;
   logic        [stqps_pkg::IDX_W-1:0]  req_entry_index = '0;
   logic signed [stqps_pkg::WORD_W-1:0] req_entry_value = '0;
   logic signed [stqps_pkg::WORD_W-1:0] req_search_key = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic                                rsp_found;
   logic        [stqps_pkg::IDX_W-1:0]  rsp_position;
   logic                                csr_wr_en = 1'b0;
   logic        [stqps_pkg::CNT_W-1:0]  csr_wr_data = '0;

   // Predictor state, updated only from beats that the block really accepted.
   logic signed [stqps_pkg::WORD_W-1:0] table_copy [stqps_pkg::TABLE_DEPTH];
   int                                  entry_limit = 0;
   lookup_result_type                   pending_answers [$];

   // Stimulus side: what the generator believes the table holds, so that it can
   // aim keys at stored values and their neighbors.
   logic signed [stqps_pkg::WORD_W-1:0] planned [stqps_pkg::TABLE_DEPTH];
   int                                  plan_count = 0;

   // Traffic shaping shared by the sender and the receiver.
   bit                       steady = 1'b0;
   int                       rsp_hold_request = 0;
   int                       hold_left = 0;

   int                       cycle_count = 0;
   int                       failures = 0;
   int                       beats_sent = 0;
   int                       searches_seen = 0;
   int                       hits_seen = 0;
   int                       count_writes = 0;

   sorted_table_quadratic_probe_search uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // The search itself. The range [lo, hi] narrows as in binary search, but the
   // probe sits at lo + max(1, floor(r*r/N)), clamped to hi. The count is capped
   // at the table depth, and a key outside the first and last entries misses at
   // once without any probe.
   function automatic lookup_result_type lookup_key(logic signed [stqps_pkg::WORD_W-1:0] key);
      lookup_result_type answer;
      longint            lo;
      longint            hi;
      longint            cur;
      longint unsigned   r;
      longint unsigned   jump;
      int                n;
      answer.found = 1'b0;
      answer.position = '0;
      n = (entry_limit > stqps_pkg::TABLE_DEPTH) ? stqps_pkg::TABLE_DEPTH : entry_limit;
      if (n == 0) return answer;
      if (key < table_copy[0] || key > table_copy[n - 1]) return answer;
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
         r = longint'(hi - lo + 1);
         jump = (r * r) / longint'(n);
         if (jump < 1) jump = 1;
         cur = lo + longint'(jump);
         if (cur > hi) cur = hi;
         if (table_copy[cur] == key) begin
            answer.found = 1'b1;
            answer.position = cur[stqps_pkg::IDX_W-1:0];
            return answer;
         end
         // An unsorted table still ends here, because each probe shrinks the range.
         if (table_copy[cur] < key) lo = cur + 1;
         else hi = cur - 1;
      end
      return answer;
   endfunction

   // Uniform value in [0, top] over the full 64-bit range.
   function automatic longint unsigned rand_upto(longint unsigned top);
      return {$urandom, $urandom} % (top + 1);
   endfunction

   // Keys aim mostly at stored values, some at their neighbors, which are often
   // absent or just outside the table, and a few anywhere in the word.
   function automatic logic signed [stqps_pkg::WORD_W-1:0] pick_key();
      int roll;
      int slot;
      roll = $urandom_range(0, 99);
      if (plan_count == 0 || roll < 10) return $urandom;
      slot = $urandom_range(0, plan_count - 1);
      if (roll < 70) return planned[slot];
      if (roll < 85) return planned[slot] + 1;
      return planned[slot] - 1;
   endfunction

   // This process watches every accepted beat and every accepted result. It runs
   // at the rising edge, where the inputs driven at the falling edge are stable and
   // the block outputs still hold their values from before the edge.
   always @(posedge clock) begin
      lookup_result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d results outstanding.",
                  pending_answers.size());
         $display("Some tests failed");
         $finish;
      end else if (!reset) begin
         if (csr_wr_en) begin
            entry_limit = int'(csr_wr_data);
            count_writes++;
         end
         if (req_valid && req_ready) begin
            // A write makes no result. A search makes exactly one, in order.
            if (req_type == stqps_pkg::REQ_WRITE) begin
               table_copy[req_entry_index] = req_entry_value;
            end else begin
               pending_answers = {pending_answers, lookup_key(req_search_key)};
               searches_seen++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               $error("result beat with no search outstanding: found %0d, position %0d",
                      rsp_found, rsp_position);
               failures++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_found !== want.found) begin
                  $error("found mismatch: expected %0d, actual %0d", want.found, rsp_found);
                  failures++;
               end
               if (rsp_position !== want.position) begin
                  $error("position mismatch: expected %0d, actual %0d",
                         want.position, rsp_position);
                  failures++;
               end
               if (want.found) hits_seen++;
            end
         end
      end
   end

   // Result receiver. It drops ready in about one cycle of five, stays ready in a
   // steady stretch, and honors a long hold-off that it counts down itself.
   always @(negedge clock) begin
      if (rsp_hold_request != 0) begin
         hold_left = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 20);
      end
   end

   // Offer one request beat and wait for it to be taken. Valid stays high after
   // the handshake until the next falling edge, where either the next beat or an
   // idle cycle replaces it.
   task automatic send_beat(input logic kind, input logic [stqps_pkg::IDX_W-1:0] idx,
                            input logic signed [stqps_pkg::WORD_W-1:0] value,
                            input logic signed [stqps_pkg::WORD_W-1:0] key);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 4);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_type <= kind;
      req_entry_index <= idx;
      req_entry_value <= value;
      req_search_key <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   // The field that a beat does not use carries random bits.
   task automatic write_entry(input int idx, input logic signed [stqps_pkg::WORD_W-1:0] value);
      planned[idx] = value;
      send_beat(stqps_pkg::REQ_WRITE, idx[stqps_pkg::IDX_W-1:0], value, $urandom);
   endtask

   task automatic search_for(input logic signed [stqps_pkg::WORD_W-1:0] key);
      send_beat(stqps_pkg::REQ_SEARCH, stqps_pkg::IDX_W'($urandom), $urandom, key);
   endtask

   // Stop offering beats and wait until every search has been answered. The
   // check at the falling edge comes after the monitor has seen the last beat.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
   endtask

   // The entry count changes only with the block idle. A trailing write makes no
   // result, so the task lets the block settle before the register write.
   task automatic set_entry_count(input int value);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[stqps_pkg::CNT_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      plan_count = (value > stqps_pkg::TABLE_DEPTH) ? stqps_pkg::TABLE_DEPTH : value;
   endtask

   // Fill entries 0 to n-1 with a non-decreasing sequence. The values come from
   // adding random steps to an offset from the most negative word. The steps are
   // small enough that the total stays within the 32-bit range.
   task automatic load_sorted_table(input int n);
      longint unsigned span;
      longint unsigned step_hi;
      longint unsigned acc;
      spread_type      spread;
      span = 64'hFFFF_FFFF;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: spread = SPREAD_WIDE;
         5, 6, 7: spread = SPREAD_MEDIUM;
         default: spread = SPREAD_DENSE;
      endcase
      case (spread)
         SPREAD_WIDE: step_hi = span / (2 * n);
         SPREAD_MEDIUM: step_hi = 1000;
         default: step_hi = 2;
      endcase
      acc = rand_upto(span - longint'(n) * step_hi);
      for (int i = 0; i < n; i++) begin
         if (i > 0) acc += rand_upto(step_hi);
         // Flipping the top bit subtracts 2**31 from the offset.
         write_entry(i, acc[stqps_pkg::WORD_W-1:0] ^ 32'h8000_0000);
      end
   endtask

   // After reset the count is zero. Every search must miss, even though the table
   // has never been written.
   task automatic test_empty_table();
      search_for(32'sh8000_0000);
      search_for(32'sh7FFF_FFFF);
      search_for(32'sd0);
      search_for($urandom);
   endtask

   // Hand-picked cases: keys below and above the table, hits on the first and
   // last entries, a miss inside the range, a one-entry table, extreme values
   // stored, the top index written, and a table with one entry out of order.
   task automatic test_directed_edges();
      logic signed [stqps_pkg::WORD_W-1:0] values [8];
      values = '{-32'sd2000000000, -32'sd70000, -32'sd5, 32'sd0,
                 32'sd3, 32'sd99, 32'sd65536, 32'sd2000000000};
      for (int i = 0; i < 8; i++) write_entry(i, values[i]);
      set_entry_count(8);
      search_for(32'sh8000_0000);
      search_for(32'sh7FFF_FFFF);
      search_for(-32'sd2000000000);
      search_for(32'sd2000000000);
      search_for(32'sd3);
      search_for(32'sd4);
      set_entry_count(1);
      search_for(-32'sd2000000000);
      search_for(-32'sd70000);
      write_entry(0, 32'sh8000_0000);
      write_entry(7, 32'sh7FFF_FFFF);
      set_entry_count(8);
      search_for(32'sh8000_0000);
      search_for(32'sh7FFF_FFFF);
      write_entry(stqps_pkg::TABLE_DEPTH - 1, 32'sh7FFF_FFFF);
      write_entry(3, 32'sd900000);
      search_for(32'sd0);
      search_for(32'sd900000);
      search_for(32'sd99);
   endtask

   // Fill the whole table, then search with the count at the table depth. Then
   // search with counts above it, which the block must treat as the full depth.
   // From here on every entry has been written, so any count is safe.
   task automatic test_full_table();
      load_sorted_table(stqps_pkg::TABLE_DEPTH);
      set_entry_count(stqps_pkg::TABLE_DEPTH);
      repeat (40) search_for(pick_key());
      set_entry_count(COUNT_MAX);
      repeat (20) search_for(pick_key());
      set_entry_count(stqps_pkg::TABLE_DEPTH + 1);
      repeat (10) search_for(pick_key());
   endtask

   // The receiver holds off for a long stretch while searches keep coming. The
   // result register and the search in flight fill up, and the request side has
   // to stall until the receiver takes results again.
   task automatic test_backpressure();
      set_entry_count($urandom_range(16, 64));
      rsp_hold_request = HOLD_CYCLES;
      repeat (16) search_for(pick_key());
      drain();
   endtask

   // Random phases. Each phase mostly loads a fresh sorted table and sets a count,
   // then issues searches with a few stray writes mixed in. A stray write inside
   // the range leaves the table unsorted. Most counts are small to keep searches
   // short. A few use the empty, full and oversized settings; those and counts
   // above 256 may keep old contents. One phase runs without idling on either side.
   task automatic test_random_tables();
      int start_beats;
      int phase;
      int n;
      int roll;
      start_beats = beats_sent;
      phase = 0;
      while (beats_sent - start_beats < RANDOM_BEATS) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) n = $urandom_range(1, 32);
         else if (roll < 85) n = $urandom_range(33, 128);
         else if (roll < 95) n = $urandom_range(129, stqps_pkg::TABLE_DEPTH - 1);
         else begin
            case ($urandom_range(0, 2))
               0: n = 0;
               1: n = stqps_pkg::TABLE_DEPTH;
               default: n = $urandom_range(stqps_pkg::TABLE_DEPTH + 1, COUNT_MAX);
            endcase
         end
         steady = (phase == 0);
         if (n > 0 && (n <= 256 || $urandom_range(0, 1) == 0)) begin
            load_sorted_table((n > stqps_pkg::TABLE_DEPTH) ? stqps_pkg::TABLE_DEPTH : n);
         end
         set_entry_count(n);
         repeat ($urandom_range(6, 24)) begin
            if ($urandom_range(0, 99) < 10) begin
               write_entry($urandom_range(0, stqps_pkg::TABLE_DEPTH - 1), $urandom);
            end else begin
               search_for(pick_key());
            end
         end
         phase++;
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_directed_edges();
      test_full_table();
      test_backpressure();
      test_random_tables();

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_answers.size() != 0) begin
         $error("%0d expected results never arrived", pending_answers.size());
         failures++;
      end
      $display("Covered %0d request beats with %0d searches (%0d hits) over %0d count settings,",
               beats_sent, searches_seen, hits_seen, count_writes);
      $display("including empty, single-entry, full, oversized and unsorted tables.");
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
